// ===== src/rec_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rec_pkg: shared types and constants of the relative energy convergence check
// Request and result codes, queue item layout, configuration bundle.
// ----------------------------------------------------------------------------
package rec_pkg;

    localparam int unsigned MAX_ITER_DEFAULT = 64;
    localparam int unsigned QUEUE_DEPTH      = 2;

    localparam logic [47:0] TOL_RESET      = 48'd1099512;  // about 1e-6 in Q8.40
    localparam logic [6:0]  MAX_ITER_RESET = 7'd25;
    localparam logic [61:0] ENERGY_MAX     = {62{1'b1}};

    // request codes on s_req_type
    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_ELEM   = 2'd1,
        REQ_HIST   = 2'd2,
        REQ_IGNORE = 2'd3
    } rec_req_t;

    // item kinds carried from front to back
    typedef enum logic [1:0] {
        K_START = 2'd0,
        K_ELEM  = 2'd1,
        K_LAST  = 2'd2,
        K_HIST  = 2'd3
    } rec_kind_t;

    typedef enum logic [2:0] {
        STAT_CONVERGED   = 3'd0,
        STAT_CONTINUE    = 3'd1,
        STAT_FAILED      = 3'd2,
        STAT_NOT_STARTED = 3'd3,
        STAT_ACCEPTED    = 3'd4,
        STAT_HISTORY     = 3'd5
    } rec_status_t;

    typedef enum logic [2:0] {
        S_RUN,
        S_HIST,
        S_ENERGY,
        S_MUL,
        S_DECIDE
    } rec_state_t;

    typedef enum logic [1:0] {
        CFG_TOL      = 2'd0,
        CFG_MAX_ITER = 2'd1,
        CFG_GO_ON    = 2'd2
    } rec_cfg_idx_t;

    typedef struct packed {
        logic [47:0] tol;
        logic [6:0]  max_iter;
        logic        go_on;
    } rec_cfg_t;

    typedef struct packed {
        rec_kind_t          kind;
        logic signed [63:0] prod;   // x_increment * residual, Q32.32
        logic [5:0]         hidx;
    } rec_entry_t;

endpackage
`default_nettype wire

// ===== src/relative_energy_convergence_check_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// relative_energy_convergence_check_core: relative energy increment test
// Streams increment/residual pairs into a saturating dot product and decides
// converged, continue, failed or accepted against tol x first iteration's energy.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  s_*       in   s_valid / s_ready   req_type, x_increment, residual,
//                                     last_element, history_index
//  m_*       out  m_valid / m_ready   status, iteration, energy
//  cfg_*     in   cfg_wr_en           cfg_index, cfg_wr_data (48 bits)
//
//  Start and non-last element items are taken in the back end's run state, so
//  element pairs stream at one per cycle while it stays there. Last element:
//  accumulate, energy, three 16x62 multiply steps forming tol x reference,
//  decide. History read: registered history memory read, then result load.
//  Reset (aresetn low, synchronous) clears queue, state, valid bits, solver state.
//  A full result register only stalls the back end; the 2-entry queue keeps
//  taking input items until it fills.
// ----------------------------------------------------------------------------
module relative_energy_convergence_check_core #(
    parameter int unsigned MAX_ITER = rec_pkg::MAX_ITER_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [47:0]        cfg_wr_data,
    // requests
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic signed [31:0] s_x_increment,
    input  logic signed [31:0] s_residual,
    input  logic               s_last_element,
    input  logic [5:0]         s_history_index,
    // results
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [7:0]         m_iteration,
    output logic [61:0]        m_energy
);
    import rec_pkg::*;

    rec_cfg_t   cfg_reg;
    logic       q_push, q_pop, q_valid;
    rec_entry_t push_entry, head_entry;

    // Configuration registers; the user must write them only while no item is in flight, the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tol      <= TOL_RESET;
            cfg_reg.max_iter <= MAX_ITER_RESET;
            cfg_reg.go_on    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (rec_cfg_idx_t'(cfg_index))
                CFG_TOL:      cfg_reg.tol      <= cfg_wr_data;
                CFG_MAX_ITER: cfg_reg.max_iter <= cfg_wr_data[6:0];
                CFG_GO_ON:    cfg_reg.go_on    <= cfg_wr_data[0];
                default: ;    // unmapped index, write dropped
            endcase
        end
    end

    // Front: decode the request and form the element product.
    rec_front u_front (
        .s_valid         (s_valid),
        .s_req_type      (s_req_type),
        .s_x_increment   (s_x_increment),
        .s_residual      (s_residual),
        .s_last_element  (s_last_element),
        .s_history_index (s_history_index),
        .q_ready         (s_ready),
        .q_push          (q_push),
        .q_entry         (push_entry)
    );

    // Queue: s_ready is simply "queue has room"; ignored requests are
    // still accepted but never enqueued.
    rec_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .in_entry  (push_entry),
        .in_ready  (s_ready),
        .pop       (q_pop),
        .out_valid (q_valid),
        .out_entry (head_entry)
    );

    // Back: accumulate, energy, history, ratio test, result register.
    rec_back #(
        .MAX_ITER (MAX_ITER)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_entry     (head_entry),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_iteration (m_iteration),
        .m_energy    (m_energy)
    );

endmodule
`default_nettype wire

// ===== src/rec_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rec_front: request classifier
// Decodes the request code, forms the element product and pushes a queue item.
// ----------------------------------------------------------------------------
module rec_front (
    input  logic                   s_valid,
    input  logic [1:0]             s_req_type,
    input  logic signed [31:0]     s_x_increment,
    input  logic signed [31:0]     s_residual,
    input  logic                   s_last_element,
    input  logic [5:0]             s_history_index,
    input  logic                   q_ready,
    output logic                   q_push,
    output rec_pkg::rec_entry_t    q_entry
);
    import rec_pkg::*;

    rec_kind_t          kind;
    logic               keep;
    logic signed [63:0] prod;

    always_comb begin
        keep = 1'b1;
        kind = K_START;
        unique case (rec_req_t'(s_req_type))
            REQ_START:  kind = K_START;
            REQ_ELEM:   kind = s_last_element ? K_LAST : K_ELEM;
            REQ_HIST:   kind = K_HIST;
            REQ_IGNORE: keep = 1'b0;   // dropped at the door
        endcase
    end

    // exact 32x32 product, registered in the queue
    assign prod    = 64'(s_x_increment) * 64'(s_residual);
    assign q_entry = {kind, prod, s_history_index};
    assign q_push  = s_valid && q_ready && keep;

endmodule
`default_nettype wire

// ===== src/rec_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rec_queue: small FIFO between front and back
// Decouples request intake from the accumulate / decide engine.
// ----------------------------------------------------------------------------
module rec_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  rec_pkg::rec_entry_t in_entry,
    output logic                in_ready,
    input  logic                pop,
    output logic                out_valid,
    output rec_pkg::rec_entry_t out_entry
);
    import rec_pkg::*;

    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    rec_entry_t     slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  cnt_reg;
    logic           do_pop;

    assign in_ready  = (cnt_reg != FULL_CNT);
    assign out_valid = (cnt_reg != '0);
    assign out_entry = slot_reg[rd_ptr_reg];
    assign do_pop    = pop && out_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !do_pop) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (do_pop && !push) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule
`default_nettype wire

// ===== src/rec_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rec_back: accumulate and decide engine
// Saturating dot product, energy, history store, ratio test, result register.
// ----------------------------------------------------------------------------
module rec_back #(
    parameter int unsigned MAX_ITER = rec_pkg::MAX_ITER_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rec_pkg::rec_cfg_t   cfg,
    input  logic                q_valid,
    input  rec_pkg::rec_entry_t q_entry,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic [7:0]          m_iteration,
    output logic [61:0]         m_energy
);
    import rec_pkg::*;

    localparam int unsigned AW = (MAX_ITER > 1) ? $clog2(MAX_ITER) : 1;
    localparam logic [8:0]  LIMIT9 = 9'(MAX_ITER);
    localparam int unsigned PRW = 110;   // 48 x 62 product

    rec_state_t      state_reg, state_next;
    logic [63:0]     acc_reg;
    logic [61:0]     ref_reg;
    logic [7:0]      count_reg;
    logic [MAX_ITER-1:0] valid_reg;
    logic [61:0]     hist_mem [MAX_ITER];
    logic [61:0]     rd_data_reg;
    logic            rd_hit_reg;
    logic [61:0]     energy_reg;
    logic [PRW-1:0]  prod_reg;
    logic [1:0]      step_reg;
    logic            m_valid_reg;
    logic [2:0]      m_status_reg;
    logic [7:0]      m_iter_reg;
    logic [61:0]     m_energy_reg;

    // saturating accumulate
    logic [64:0]     sum_wide;
    logic [63:0]     sum_sat;
    assign sum_wide = {acc_reg[63], acc_reg} + {q_entry.prod[63], q_entry.prod};
    always_comb begin
        if (sum_wide[64] != sum_wide[63]) begin
            sum_sat = sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            sum_sat = sum_wide[63:0];
        end
    end

    // energy = |acc| / 2, clamped to 62 bits
    logic [63:0]     mag;
    logic [61:0]     energy_calc;
    assign mag         = acc_reg[63] ? (~acc_reg + 64'd1) : acc_reg;
    assign energy_calc = mag[63] ? ENERGY_MAX : mag[62:1];

    // history addressing
    logic [AW-1:0]   rd_addr, wr_addr;
    logic            rd_in_range, hist_we;
    assign rd_addr     = AW'(q_entry.hidx);
    assign rd_in_range = (9'(q_entry.hidx) < LIMIT9);
    assign wr_addr     = AW'(count_reg - 8'd1);
    assign hist_we     = (state_reg == S_ENERGY) && (count_reg != 8'd0)
                      && (count_reg <= 8'(cfg.max_iter)) && (9'(count_reg) <= LIMIT9);

    // tol x ref, one 16-bit slice of tol per step, high slice first
    logic [15:0]     tol_slice;
    logic [77:0]     part_prod;
    always_comb begin
        unique case (step_reg)
            2'd0:    tol_slice = cfg.tol[47:32];
            2'd1:    tol_slice = cfg.tol[31:16];
            2'd2:    tol_slice = cfg.tol[15:0];
            default: tol_slice = '0;
        endcase
    end
    assign part_prod = 78'(tol_slice) * 78'(ref_reg);

    // ratio test and verdict
    logic            conv, at_limit;
    rec_status_t     verdict;
    always_comb begin
        if (ref_reg != '0) begin
            conv = (PRW'({energy_reg, 40'd0}) <= prod_reg);
        end else begin
            conv = (PRW'({energy_reg, 8'd0}) <= PRW'(cfg.tol));
        end
        at_limit = (count_reg >= 8'(cfg.max_iter));
        priority if (conv) begin
            verdict = STAT_CONVERGED;
        end else if (at_limit) begin
            verdict = cfg.go_on ? STAT_ACCEPTED : STAT_FAILED;
        end else begin
            verdict = STAT_CONTINUE;
        end
    end

    logic            slot_free;
    assign slot_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_RUN: begin
                if (q_valid) begin
                    if (q_entry.kind == K_LAST) begin
                        state_next = S_ENERGY;
                    end else if (q_entry.kind == K_HIST) begin
                        state_next = S_HIST;
                    end
                end
            end
            S_HIST: begin
                if (slot_free) state_next = S_RUN;
            end
            S_ENERGY: begin
                if (count_reg != 8'd0) begin
                    state_next = S_MUL;
                end else if (slot_free) begin
                    state_next = S_RUN;
                end
            end
            S_MUL: begin
                if (step_reg == 2'd2) state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (slot_free) state_next = S_RUN;
            end
            default: state_next = S_RUN;
        endcase
    end

    // outputs
    logic            res_load, bump;
    rec_status_t     res_status;
    logic [7:0]      res_iter;
    logic [61:0]     res_energy;
    always_comb begin
        q_pop      = 1'b0;
        res_load   = 1'b0;
        bump       = 1'b0;
        res_status = verdict;
        res_iter   = count_reg;
        res_energy = energy_reg;
        unique case (state_reg)
            S_RUN: q_pop = q_valid;
            S_HIST: begin
                res_load   = slot_free;
                res_status = STAT_HISTORY;
                res_energy = rd_hit_reg ? rd_data_reg : '0;
            end
            S_ENERGY: begin
                if (count_reg == 8'd0) begin
                    res_load   = slot_free;
                    res_status = STAT_NOT_STARTED;
                    res_energy = '0;
                end
            end
            S_MUL: ;
            S_DECIDE: begin
                res_load = slot_free;
                bump     = slot_free && (verdict == STAT_FAILED || verdict == STAT_CONTINUE);
            end
            default: ;
        endcase
    end

    // control and solver state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_RUN;
            acc_reg     <= '0;
            ref_reg     <= '0;
            count_reg   <= '0;
            valid_reg   <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (q_pop) begin
                unique case (q_entry.kind)
                    K_START: begin
                        acc_reg   <= '0;
                        ref_reg   <= '0;
                        count_reg <= 8'd1;
                        valid_reg <= '0;
                    end
                    K_ELEM, K_LAST: acc_reg <= sum_sat;
                    K_HIST: ;
                endcase
            end
            if (state_reg == S_ENERGY) begin
                acc_reg  <= '0;
                step_reg <= '0;
                if (count_reg == 8'd1) ref_reg <= energy_calc;
                if (hist_we) valid_reg[wr_addr] <= 1'b1;
            end
            if (state_reg == S_MUL) begin
                step_reg <= step_reg + 2'd1;
            end
            if (bump && count_reg != 8'hFF) begin
                count_reg <= count_reg + 8'd1;
            end
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath payload
    always_ff @(posedge aclk) begin
        if (q_pop && q_entry.kind == K_HIST) begin
            rd_data_reg <= hist_mem[rd_addr];
            rd_hit_reg  <= rd_in_range && valid_reg[rd_addr];
        end
        if (state_reg == S_ENERGY) begin
            energy_reg <= energy_calc;
            prod_reg   <= '0;
        end
        if (state_reg == S_MUL) begin
            prod_reg <= (prod_reg << 16) + PRW'(part_prod);
        end
        if (res_load) begin
            m_status_reg <= res_status;
            m_iter_reg   <= res_iter;
            m_energy_reg <= res_energy;
        end
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[wr_addr] <= energy_calc;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_iteration = m_iter_reg;
    assign m_energy    = m_energy_reg;

endmodule
`default_nettype wire
